>>> rtl/fhd_pkg.sv
// shared types and constants for the frame header deframer
package fhd_pkg;

  localparam int HEADER_BYTES = 36;
  localparam int HCOUNT_W     = 6;

  // byte offsets of the header fields
  localparam int DATA_BASE   = 4;
  localparam int STREAM_BASE = 8;
  localparam int FRAME_BASE  = 12;
  localparam int SIZE_BASE   = 16;
  localparam int SEQ_BASE    = 20;
  localparam int TIME_BASE   = 28;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_PAYLOAD_W = 24;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 24'd3145692;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER_FLAG = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic ERR_BAD_FLAG  = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  // result payload, first member at the top
  typedef struct packed {
    logic [6:0]               pad;
    logic                     fault_code;
    logic [7:0]               payload_byte;
    logic [63:0]              time_stamp;
    logic [63:0]              seq_number;
    logic [MAX_PAYLOAD_W-1:0] payload_size;
    logic [31:0]              frame_kind;
    logic [31:0]              stream_kind;
    logic [31:0]              data_kind;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

>>> rtl/frame_header_deframer_unit.sv
// frame header deframer: byte stream in, header, payload and error results out
// datapath: an accepted byte passes the input register, then the result register
// throughput: one byte per cycle unless m_tready stalls the result register; set by
//   the single-pass header capture and payload counter between the two registers
// reset: synchronous rst clears the handshake stages, returns to header
//   collection and loads the register reset values
module frame_header_deframer_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [fhd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [fhd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // data_byte
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // data_kind, stream_kind, frame_kind, payload_size, seq_number, time_stamp,
  // payload_byte, fault_code, zero pad
  output logic [fhd_pkg::RESULT_W-1:0]          m_tdata,
  output logic [1:0]                            m_tuser,   // kind
  output logic                                  m_tlast    // last
);

  // configuration
  logic [31:0]                            header_flag;
  logic [fhd_pkg::MAX_PAYLOAD_W-1:0]      max_payload_bytes;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // deframer state
  logic                                   in_payload, in_payload_next;
  logic [fhd_pkg::HCOUNT_W-1:0]           header_count, header_count_next;
  logic [31:0]                            flag_shift, flag_shift_next;
  logic [31:0]                            data_kind_reg, data_kind_reg_next;
  logic [31:0]                            stream_kind_reg, stream_kind_reg_next;
  logic [31:0]                            frame_kind_reg, frame_kind_reg_next;
  logic [31:0]                            size_reg, size_reg_next;
  logic [63:0]                            seq_reg, seq_reg_next;
  logic [63:0]                            time_reg, time_reg_next;
  logic [fhd_pkg::MAX_PAYLOAD_W-1:0]      payload_left, payload_left_next;
  logic [fhd_pkg::MAX_PAYLOAD_W-1:0]      left_dec;
  logic [2:0]                             seq_idx, time_idx;

  // result
  logic                                   res_valid;
  fhd_pkg::kind_t                         res_kind;
  logic                                   res_last;
  fhd_pkg::result_t                       res_data;

  logic out_free;
  logic proc_fire;

  assign out_free  = !m_tvalid || m_tready;
  assign proc_fire = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  assign seq_idx  = 3'(header_count - fhd_pkg::HCOUNT_W'(fhd_pkg::SEQ_BASE));
  assign time_idx = 3'(header_count - fhd_pkg::HCOUNT_W'(fhd_pkg::TIME_BASE));
  assign left_dec = payload_left - fhd_pkg::MAX_PAYLOAD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_flag       <= '0;
      max_payload_bytes <= fhd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        fhd_pkg::REG_HEADER_FLAG: header_flag <= cfg_wdata;
        fhd_pkg::REG_MAX_PAYLOAD:
          max_payload_bytes <= cfg_wdata[fhd_pkg::MAX_PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    in_payload_next      = in_payload;
    header_count_next    = header_count;
    flag_shift_next      = flag_shift;
    data_kind_reg_next   = data_kind_reg;
    stream_kind_reg_next = stream_kind_reg;
    frame_kind_reg_next  = frame_kind_reg;
    size_reg_next        = size_reg;
    seq_reg_next         = seq_reg;
    time_reg_next        = time_reg;
    payload_left_next    = payload_left;
    res_valid            = 1'b0;
    res_kind             = fhd_pkg::KIND_HEADER;
    res_last             = 1'b0;
    res_data             = '0;

    if (in_payload) begin
      payload_left_next     = left_dec;
      res_valid             = 1'b1;
      res_kind              = fhd_pkg::KIND_PAYLOAD;
      res_data.payload_byte = in_byte;
      if (left_dec == '0) begin
        res_last          = 1'b1;
        in_payload_next   = 1'b0;
        header_count_next = '0;
      end
    end else begin
      // each header byte lands in its field; fields are fully rewritten per frame
      if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::DATA_BASE)) begin
        flag_shift_next = {in_byte, flag_shift[31:8]};
      end else if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::STREAM_BASE)) begin
        data_kind_reg_next[8*header_count[1:0] +: 8] = in_byte;
      end else if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::FRAME_BASE)) begin
        stream_kind_reg_next[8*header_count[1:0] +: 8] = in_byte;
      end else if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::SIZE_BASE)) begin
        frame_kind_reg_next[8*header_count[1:0] +: 8] = in_byte;
      end else if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::SEQ_BASE)) begin
        size_reg_next[8*header_count[1:0] +: 8] = in_byte;
      end else if (header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::TIME_BASE)) begin
        seq_reg_next[8*seq_idx +: 8] = in_byte;
      end else begin
        time_reg_next[8*time_idx +: 8] = in_byte;
      end

      if (header_count == fhd_pkg::HCOUNT_W'(fhd_pkg::DATA_BASE - 1) &&
          flag_shift_next != header_flag) begin
        // bad start flag: hunt from the next byte
        res_valid           = 1'b1;
        res_kind            = fhd_pkg::KIND_ERROR;
        res_data.fault_code = fhd_pkg::ERR_BAD_FLAG;
        header_count_next   = '0;
      end else if (header_count != fhd_pkg::HCOUNT_W'(fhd_pkg::HEADER_BYTES - 1)) begin
        header_count_next = header_count + fhd_pkg::HCOUNT_W'(1);
      end else if (size_reg > {8'd0, max_payload_bytes}) begin
        res_valid           = 1'b1;
        res_kind            = fhd_pkg::KIND_ERROR;
        res_data.fault_code = fhd_pkg::ERR_TOO_LARGE;
        header_count_next   = '0;
      end else begin
        res_valid             = 1'b1;
        res_kind              = fhd_pkg::KIND_HEADER;
        res_data.data_kind    = data_kind_reg;
        res_data.stream_kind  = stream_kind_reg;
        res_data.frame_kind   = frame_kind_reg;
        res_data.payload_size = size_reg[fhd_pkg::MAX_PAYLOAD_W-1:0];
        res_data.seq_number   = seq_reg;
        res_data.time_stamp   = time_reg_next;
        header_count_next     = '0;
        if (size_reg == '0) begin
          res_last = 1'b1;
        end else begin
          payload_left_next = size_reg[fhd_pkg::MAX_PAYLOAD_W-1:0];
          in_payload_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_count <= '0;
      payload_left <= '0;
    end else if (proc_fire) begin
      in_payload   <= in_payload_next;
      header_count <= header_count_next;
      payload_left <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      flag_shift      <= flag_shift_next;
      data_kind_reg   <= data_kind_reg_next;
      stream_kind_reg <= stream_kind_reg_next;
      frame_kind_reg  <= frame_kind_reg_next;
      size_reg        <= size_reg_next;
      seq_reg         <= seq_reg_next;
      time_reg        <= time_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= proc_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

  // header counter stays inside the header
  assert property (@(posedge clk) disable iff (rst)
    header_count < fhd_pkg::HCOUNT_W'(fhd_pkg::HEADER_BYTES))
    else $error("header count ran past the header");

  // a payload run always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (payload_left != '0))
    else $error("payload run with no bytes left");

  // the final payload byte ends the run
  assert property (@(posedge clk) disable iff (rst)
    (proc_fire && in_payload && payload_left == fhd_pkg::MAX_PAYLOAD_W'(1))
      |=> (!in_payload && header_count == '0 && m_tvalid && m_tlast))
    else $error("final payload byte did not close the frame");

  // a marked header result carries an empty payload
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fhd_pkg::KIND_HEADER && m_tlast)
      |-> (m_tdata[119:96] == '0))
    else $error("header marked last with a nonzero payload size");

endmodule
